// ===== rtl/src_pkg.sv =====
// ============================================================================
// src_pkg: shared types and constants for the spectrogram row colorizer
// Sizes of the row history, the register map and the colour stop packing.
// ============================================================================
`default_nettype none

package src_pkg;

    localparam int ROWS  = 64;
    localparam int COLS  = 1024;
    localparam int SLOTS = ROWS + 1;
    localparam int STOPS = 6;

    localparam int COL_W   = 10;
    localparam int SLOT_W  = 7;
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int WIDTH_W = 11;
    localparam int STOP_W  = 41;
    localparam int POS_W   = 17;

    // divider: 33-bit dividend, 17-bit divisor, one bit per cycle
    localparam int DIV_N_W = 33;
    localparam int DIV_D_W = 17;

    // register indexes
    localparam logic [2:0] REG_ROW_WIDTH  = 3'd0;
    localparam logic [2:0] REG_STOP_COUNT = 3'd1;
    localparam logic [2:0] REG_STOP_FIRST = 3'd2;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef logic [STOP_W-1:0] stop_t;

    // position field of a colour stop
    function automatic logic [POS_W-1:0] stop_pos(input stop_t s);
        stop_pos = s[40:24];
    endfunction

    // colour byte of a stop: 0 red, 1 green, 2 blue
    function automatic logic [7:0] stop_chan(input stop_t s, input logic [1:0] ch);
        case (ch)
            2'd0:    stop_chan = s[23:16];
            2'd1:    stop_chan = s[15:8];
            default: stop_chan = s[7:0];
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spectrogram_row_colorizer_unit.sv =====
// ============================================================================
// spectrogram_row_colorizer_unit
// Waterfall history of spectrum rows with a colour ramp lookup per pixel.
// ============================================================================
// A push request appends one bin to the row being filled; the last bin of a
// row commits it. A fetch request keeps the input busy from accept to result:
// a memory read, two passes of a shared restoring divider that retires one
// quotient bit a cycle (for the normalization and the ramp fraction), a match
// step, a step to sign the fraction, a multiply and an accumulate step per
// colour channel on one shared multiplier, and a load of the output register.
// A fetch that lands on the grey ramp skips the second division and the
// channels; a stop pair with no positive span skips the second division and
// the sign step. A fetch with no committed row goes straight to the output
// register. The block takes one request at a time; a finished pixel sits in
// the output register so the next request can enter while it waits, and a
// full output register stretches a fetch until the pixel is taken. There is no
// clearing pass: writing row_width only resets the row counters.
`default_nettype none

module spectrogram_row_colorizer_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_en,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [src_pkg::STOP_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       operation,
    input  wire logic [15:0]                magnitude,
    input  wire logic [5:0]                 row_age,
    input  wire logic [9:0]                 column,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            present,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue
);
    import src_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_MATCH = 4'd3;
    localparam logic [3:0] S_DIV2  = 4'd4;
    localparam logic [3:0] S_UFIX  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // configuration
    logic [WIDTH_W-1:0] row_width_reg;
    logic [2:0]         stop_count_reg;
    stop_t              stop_reg [STOPS];

    // history control
    logic [15:0]       running_peak_reg;
    logic [COL_W-1:0]  write_column_reg;
    logic [SLOT_W-1:0] write_slot_reg;
    logic [SLOT_W-1:0] newest_slot_reg;
    logic [SLOT_W-1:0] rows_filled_reg;

    // memories
    logic [15:0] sample_mem [SLOTS*COLS];
    logic [15:0] peak_mem [SLOTS];
    logic [15:0] rd_sample_reg;
    logic [15:0] rd_peak_reg;

    // sequencer and datapath
    logic [3:0]         state_reg;
    logic               col_ok_reg;
    logic [2:0]         idx_reg;
    logic               neg_reg;
    logic [1:0]         ch_reg;
    logic signed [34:0] u_reg;
    logic signed [43:0] prod_reg;
    logic [7:0]         rgb_reg [3];
    logic               res_present_reg;

    logic [DIV_D_W-1:0] div_rem_reg;
    logic [DIV_N_W-1:0] div_quo_reg;
    logic [DIV_D_W-1:0] div_d_reg;
    logic [5:0]         div_cnt_reg;

    logic        out_valid_reg;
    logic        out_present_reg;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    logic [7:0]  out_blue_reg;

    logic in_fire;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // push path
    logic              push_fire;
    logic [15:0]       peak_upd;
    logic              row_end;
    assign push_fire = in_fire && (operation == OP_PUSH);
    assign peak_upd  = (magnitude > running_peak_reg) ? magnitude : running_peak_reg;
    assign row_end   = ({1'b0, write_column_reg} + 11'd1) >= row_width_reg;

    // fetch slot by clamped age
    logic [SLOT_W-1:0] age_cl;
    logic [SLOT_W-1:0] rd_slot;
    always_comb
    begin
        age_cl = ({1'b0, row_age} > (rows_filled_reg - 7'd1)) ? (rows_filled_reg - 7'd1)
                                                             : {1'b0, row_age};
        if (newest_slot_reg >= age_cl)
            rd_slot = newest_slot_reg - age_cl;
        else
            rd_slot = SLOT_W'(newest_slot_reg + 7'(SLOTS) - age_cl);
    end

    // store samples and read one per cycle
    always_ff @(posedge clk)
    begin
        if (push_fire)
            sample_mem[{write_slot_reg, write_column_reg}] <= magnitude;
        rd_sample_reg <= sample_mem[{rd_slot, column}];
    end

    always_ff @(posedge clk)
    begin
        if (push_fire && row_end)
            peak_mem[write_slot_reg] <= peak_upd;
        rd_peak_reg <= peak_mem[rd_slot];
    end

    // divider step
    logic [DIV_D_W:0]   div_trial;
    logic               div_bit;
    logic [DIV_D_W-1:0] div_rem_step;
    always_comb
    begin
        div_trial    = {div_rem_reg, div_quo_reg[DIV_N_W-1]};
        div_bit      = (div_trial >= {1'b0, div_d_reg});
        div_rem_step = div_bit ? DIV_D_W'(div_trial - {1'b0, div_d_reg})
                               : div_trial[DIV_D_W-1:0];
    end

    // clamp the normalized value and find the stop pair
    logic [POS_W-1:0] t_c;
    logic [2:0]       n_c;
    logic             found_c;
    logic [2:0]       idx_c;
    always_comb
    begin
        t_c = (div_quo_reg > 33'd65536) ? 17'h10000 : div_quo_reg[POS_W-1:0];
        n_c = (stop_count_reg > 3'(STOPS)) ? 3'(STOPS) : stop_count_reg;
        found_c = 1'b0;
        idx_c   = 3'd0;
        for (int i = 0; i < STOPS - 1; i++)
        begin
            if (!found_c && (4'(i + 1) < {1'b0, n_c}) && (t_c <= stop_pos(stop_reg[i + 1])))
            begin
                found_c = 1'b1;
                idx_c   = 3'(i);
            end
        end
    end

    // selected pair
    logic [POS_W-1:0]   p0_c;
    logic [POS_W-1:0]   p1_c;
    logic signed [17:0] span_c;
    logic signed [17:0] diff_c;
    logic [16:0]        diff_abs_c;
    always_comb
    begin
        p0_c       = stop_pos(stop_reg[idx_c]);
        p1_c       = stop_pos(stop_reg[3'(idx_c + 3'd1)]);
        span_c     = $signed({1'b0, p1_c}) - $signed({1'b0, p0_c});
        diff_c     = $signed({1'b0, t_c}) - $signed({1'b0, p0_c});
        diff_abs_c = diff_c[17] ? 17'(-diff_c) : diff_c[16:0];
    end

    // grey ramp
    logic [24:0] grey_full;
    logic [7:0]  grey_c;
    assign grey_full = {t_c, 8'd0} - {8'd0, t_c};
    assign grey_c    = grey_full[23:16] | {8{grey_full[24]}};

    // signed fraction from the second quotient
    logic [33:0]        u_mag;
    logic signed [34:0] u_c;
    assign u_mag = {1'b0, div_quo_reg} + {33'd0, neg_reg && (div_rem_reg != '0)};
    assign u_c   = neg_reg ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});

    // channel interpolation
    logic [7:0]         c0_c;
    logic [7:0]         c1_c;
    logic signed [8:0]  cdiff_c;
    logic signed [43:0] prod_c;
    logic signed [28:0] acc_c;
    logic [7:0]         sat_c;
    always_comb
    begin
        c0_c    = stop_chan(stop_reg[idx_reg], ch_reg);
        c1_c    = stop_chan(stop_reg[3'(idx_reg + 3'd1)], ch_reg);
        cdiff_c = $signed({1'b0, c1_c}) - $signed({1'b0, c0_c});
        prod_c  = cdiff_c * u_reg;
        acc_c   = $signed({prod_reg[43], prod_reg[43:16]}) + $signed({21'd0, c0_c});
        if (acc_c < 0)
            sat_c = 8'd0;
        else if (acc_c > 29'sd255)
            sat_c = 8'd255;
        else
            sat_c = acc_c[7:0];
    end

    // configuration and history counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= 11'(COLS);
            stop_count_reg   <= '0;
            for (int i = 0; i < STOPS; i++)
                stop_reg[i] <= '0;
            running_peak_reg <= '0;
            write_column_reg <= '0;
            write_slot_reg   <= '0;
            newest_slot_reg  <= '0;
            rows_filled_reg  <= '0;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:
                begin
                    if (cfg_data[10:0] == 11'd0)
                        row_width_reg <= 11'd1;
                    else if (cfg_data[10:0] > 11'(COLS))
                        row_width_reg <= 11'(COLS);
                    else
                        row_width_reg <= cfg_data[10:0];
                    running_peak_reg <= '0;
                    write_column_reg <= '0;
                    write_slot_reg   <= '0;
                    newest_slot_reg  <= '0;
                    rows_filled_reg  <= '0;
                end
                REG_STOP_COUNT:
                    stop_count_reg <= cfg_data[2:0];
                default:
                    stop_reg[3'(cfg_index - REG_STOP_FIRST)] <= cfg_data;
            endcase
        end
        else if (push_fire)
        begin
            if (row_end)
            begin
                newest_slot_reg  <= write_slot_reg;
                write_slot_reg   <= (write_slot_reg == 7'(SLOTS - 1)) ? 7'd0
                                                                     : write_slot_reg + 7'd1;
                if (rows_filled_reg < 7'(ROWS))
                    rows_filled_reg <= rows_filled_reg + 7'd1;
                running_peak_reg <= '0;
                write_column_reg <= '0;
            end
            else
            begin
                running_peak_reg <= peak_upd;
                write_column_reg <= write_column_reg + 10'd1;
            end
        end
    end

    // fetch sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            div_cnt_reg     <= '0;
            ch_reg          <= '0;
            col_ok_reg      <= 1'b0;
            idx_reg         <= '0;
            neg_reg         <= 1'b0;
            u_reg           <= '0;
            prod_reg        <= '0;
            for (int k = 0; k < 3; k++)
                rgb_reg[k] <= '0;
            res_present_reg <= 1'b0;
            div_rem_reg     <= '0;
            div_quo_reg     <= '0;
            div_d_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && (operation == OP_FETCH))
                    begin
                        col_ok_reg <= ({1'b0, column} < row_width_reg);
                        if (rows_filled_reg == '0)
                        begin
                            res_present_reg <= 1'b0;
                            for (int k = 0; k < 3; k++)
                                rgb_reg[k] <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            res_present_reg <= 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    div_rem_reg <= '0;
                    div_quo_reg <= {1'b0, (col_ok_reg ? rd_sample_reg : 16'd0), 16'd0};
                    div_d_reg   <= (rd_peak_reg == 16'd0) ? 17'd1 : {1'b0, rd_peak_reg};
                    div_cnt_reg <= 6'(DIV_N_W);
                    state_reg   <= S_DIV1;
                end
                S_DIV1, S_DIV2:
                begin
                    div_rem_reg <= div_rem_step;
                    div_quo_reg <= {div_quo_reg[DIV_N_W-2:0], div_bit};
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd1)
                        state_reg <= (state_reg == S_DIV1) ? S_MATCH : S_UFIX;
                end
                S_MATCH:
                begin
                    idx_reg <= idx_c;
                    neg_reg <= diff_c[17];
                    ch_reg  <= 2'd0;
                    if (!found_c)
                    begin
                        for (int k = 0; k < 3; k++)
                            rgb_reg[k] <= grey_c;
                        state_reg <= S_DONE;
                    end
                    else if (span_c > 0)
                    begin
                        div_rem_reg <= '0;
                        div_quo_reg <= {diff_abs_c, 16'd0};
                        div_d_reg   <= span_c[16:0];
                        div_cnt_reg <= 6'(DIV_N_W);
                        state_reg   <= S_DIV2;
                    end
                    else
                    begin
                        u_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_UFIX:
                begin
                    u_reg     <= u_c;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= prod_c;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    rgb_reg[ch_reg] <= sat_c;
                    if (ch_reg == 2'd2)
                        state_reg <= S_DONE;
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // output register
    logic out_load;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_present_reg <= res_present_reg;
            out_red_reg     <= rgb_reg[0];
            out_green_reg   <= rgb_reg[1];
            out_blue_reg    <= rgb_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign present   = out_present_reg;
    assign red       = out_red_reg;
    assign green     = out_green_reg;
    assign blue      = out_blue_reg;

    // checks
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rows_filled_reg <= 7'(ROWS))
        else $error("rows_filled beyond history depth");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (write_slot_reg < 7'(SLOTS)) && (newest_slot_reg < 7'(SLOTS)))
        else $error("ring slot out of range");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV1) || (state_reg == S_DIV2)) |-> (div_cnt_reg != 6'd0))
        else $error("divider running with zero count");

    a_empty_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (operation == OP_FETCH) && (rows_filled_reg == '0)) |=>
        (state_reg == S_DONE) && !res_present_reg)
        else $error("fetch on empty history not finished at once");

endmodule

`default_nettype wire

// ===== tb/spectrogram_row_colorizer_unit_tb.sv =====
// ============================================================================
// spectrogram_row_colorizer_unit_tb: self-checking bench for the row colorizer
// Drives push and fetch requests with random gaps and output stalls, predicts
// every pixel from a behavioral copy of the row history and colour ramp, and
// compares results in order. Register settings change between idle phases.
// ============================================================================
`default_nettype none

module spectrogram_row_colorizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import src_pkg::*;

    typedef struct packed {
        logic       present;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic       op;
        logic [15:0] mag;
        logic [5:0] age;
        logic [9:0] col;
        logic       has_pix;
        pixel_t     pix;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_en;
    logic [2:0]        cfg_index;
    logic [STOP_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [15:0]       magnitude;
    logic [5:0]        row_age;
    logic [9:0]        column;
    logic              out_valid;
    logic              out_ready;
    logic              present;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;

    spectrogram_row_colorizer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .magnitude(magnitude),
        .row_age(row_age), .column(column),
        .out_valid(out_valid), .out_ready(out_ready),
        .present(present), .red(red), .green(green), .blue(blue)
    );

    // shadow of the block state
    logic [15:0] hist_bins [SLOTS*COLS];
    logic [15:0] hist_peaks [SLOTS];
    int unsigned cur_peak, wr_col, wr_slot, last_slot, rows_held;
    int unsigned width_cfg, stops_cfg;
    stop_t       ramp [STOPS];

    pixel_t pending_pixels [$];
    int     errors;
    int     mismatches;
    int     pixels_seen;
    int     stall_hold;
    bit     quiet;
    bit     long_stall_req;
    bit     long_stall_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic logic [7:0] clamp_byte(longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    task automatic apply_reg(input logic [2:0] idx, input logic [STOP_W-1:0] val);
        int unsigned w;
        if (idx == REG_ROW_WIDTH) begin
            w = val[10:0];
            if (w < 1)
                w = 1;
            if (w > COLS)
                w = COLS;
            width_cfg = w;
            cur_peak = 0; wr_col = 0; wr_slot = 0; last_slot = 0; rows_held = 0;
        end else if (idx == REG_STOP_COUNT) begin
            stops_cfg = val[2:0];
        end else if (idx >= REG_STOP_FIRST && idx <= REG_STOP_FIRST + 5) begin
            ramp[idx - REG_STOP_FIRST] = val;
        end
    endtask

    // advance the shadow history by one request, return a pixel for a fetch
    function automatic bit colorize_step(input logic op, input logic [15:0] mag,
                                         input logic [5:0] age_in,
                                         input logic [9:0] col, output pixel_t px);
        int unsigned age, slot, bin, pk, n;
        longint t, p0, p1, span, u, c0, c1;
        logic [7:0] ch [3];
        bit hit;
        px = '0;
        hit = 0;
        if (op == OP_PUSH) begin
            if (wr_col < width_cfg) begin
                hist_bins[wr_slot*COLS + wr_col] = mag;
                if (mag > cur_peak)
                    cur_peak = mag;
                wr_col++;
            end
            if (wr_col >= width_cfg) begin
                hist_peaks[wr_slot] = cur_peak[15:0];
                last_slot = wr_slot;
                wr_slot = (wr_slot + 1) % SLOTS;
                if (rows_held < ROWS)
                    rows_held++;
                cur_peak = 0;
                wr_col = 0;
            end
            return 0;
        end
        if (rows_held == 0)
            return 1;
        age = age_in;
        if (age > rows_held - 1)
            age = rows_held - 1;
        slot = (last_slot + SLOTS - age) % SLOTS;
        bin = (col < width_cfg) ? hist_bins[slot*COLS + col] : 0;
        pk = hist_peaks[slot];
        if (pk == 0)
            pk = 1;
        t = (longint'(bin) << 16) / pk;
        if (t > 65536)
            t = 65536;
        n = (stops_cfg > STOPS) ? STOPS : stops_cfg;
        for (int i = 0; i + 1 < n && !hit; i++) begin
            p0 = ramp[i][40:24];
            p1 = ramp[i+1][40:24];
            if (t <= p1) begin
                span = p1 - p0;
                u = (span > 0) ? floor_div((t - p0) * 65536, span) : 0;
                for (int c = 0; c < 3; c++) begin
                    c0 = ramp[i][16 - 8*c +: 8];
                    c1 = ramp[i+1][16 - 8*c +: 8];
                    ch[c] = clamp_byte(c0 + floor_div((c1 - c0) * u, 65536));
                end
                hit = 1;
            end
        end
        if (!hit) begin
            ch[0] = 8'((t * 255) >> 16);
            ch[1] = ch[0];
            ch[2] = ch[0];
        end
        px.present = 1'b1;
        px.red = ch[0];
        px.green = ch[1];
        px.blue = ch[2];
        return 1;
    endfunction

    // write one register while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [STOP_W-1:0] val);
        in_valid  <= 1'b0;
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_en    <= 1'b0;
        @(posedge clk);
        apply_reg(idx, val);
    endtask

    // present one request and hold it until accepted
    task automatic send_request(input logic op, input logic [15:0] mag,
                                input logic [5:0] age, input logic [9:0] col,
                                input bit gaps);
        pixel_t px;
        int gap;
        if (gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        magnitude <= mag;
        row_age   <= age;
        column    <= col;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (colorize_step(op, mag, age, col, px))
            pending_pixels.insert(pending_pixels.size(), px);
    endtask

    // drop the request line and wait for a clock edge
    task automatic release_input;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        release_input();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic stop_t rand_stop();
        stop_t s;
        s[40:24] = 17'($urandom_range(0, 131071));
        if ($urandom_range(0, 3) != 0)
            s[40:24] = 17'($urandom_range(0, 65536));
        s[23:0] = 24'($urandom);
        return s;
    endfunction

    // ramp with random colours, and sorted positions from 0 to 1.0 when asked
    task automatic load_ramp(input int unsigned cnt, input bit sorted);
        stop_t s;
        write_reg(REG_STOP_COUNT, STOP_W'(cnt));
        for (int i = 0; i < STOPS; i++) begin
            s = rand_stop();
            if (sorted)
                s[40:24] = (i == STOPS - 1) ? 17'd65536 : 17'(i * 13107);
            write_reg(3'(REG_STOP_FIRST + i), s);
        end
    endtask

    // check results in arrival order
    always @(posedge clk) begin
        pixel_t want;
        if (rst_n && out_valid && out_ready) begin
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected pixel %0d/%0d/%0d/%0d", present, red, green, blue);
                mismatches++;
            end else begin
                want = pending_pixels[0];
                pending_pixels.delete(0);
                if (want.present !== present || want.red !== red ||
                    want.green !== green || want.blue !== blue) begin
                    errors++;
                    if (mismatches < 10)
                        $display("pixel mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 want.present, want.red, want.green, want.blue,
                                 present, red, green, blue);
                    mismatches++;
                end
            end
        end
    end

    // random receiver stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready       <= 1'b0;
            stall_hold      <= 0;
            long_stall_done <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            out_ready  <= 1'b0;
        end else if (long_stall_req && !long_stall_done) begin
            stall_hold      <= 400;
            long_stall_done <= 1'b1;
            out_ready       <= 1'b0;
        end else if (quiet) begin
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_hold <= $urandom_range(1, 10);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    dir_row_t dir_rows [$];
    int unsigned pushes, fetches;

    function automatic void add_row(input dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    initial begin
        pixel_t zero_px;
        logic [15:0] m;
        zero_px = '0;
        errors = 0; mismatches = 0; pixels_seen = 0; quiet = 0; long_stall_req = 0;
        pushes = 0; fetches = 0;
        rst_n = 1'b0;
        cfg_en = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; operation = OP_PUSH; magnitude = '0; row_age = '0; column = '0;
        width_cfg = COLS; stops_cfg = 0;
        cur_peak = 0; wr_col = 0; wr_slot = 0; last_slot = 0; rows_held = 0;
        for (int i = 0; i < STOPS; i++)
            ramp[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: width 4 rows, empty fetch, extremes, an all-zero row
        write_reg(REG_ROW_WIDTH, STOP_W'(11'd4));
        add_row('{OP_FETCH, 16'd0, 6'd63, 10'd1023, 1'b1, zero_px});
        add_row('{OP_PUSH, 16'hFFFF, 6'd0, 10'd0, 1'b0, zero_px});
        add_row('{OP_PUSH, 16'd0, 6'd0, 10'd0, 1'b0, zero_px});
        add_row('{OP_PUSH, 16'h8000, 6'd0, 10'd0, 1'b0, zero_px});
        add_row('{OP_PUSH, 16'd1, 6'd0, 10'd0, 1'b0, zero_px});
        // full-scale bin, grey with no stops
        add_row('{OP_FETCH, 16'd0, 6'd0, 10'd0, 1'b1, pixel_t'({1'b1, 24'hFFFFFF})});
        add_row('{OP_FETCH, 16'd0, 6'd0, 10'd1, 1'b1, pixel_t'({1'b1, 24'h0})});
        // column past the width reads black
        add_row('{OP_FETCH, 16'd0, 6'd0, 10'd1023, 1'b1, pixel_t'({1'b1, 24'h0})});
        add_row('{OP_FETCH, 16'd0, 6'd63, 10'd2, 1'b0, zero_px});
        // all-zero row: zero peak
        for (int i = 0; i < 4; i++)
            add_row('{OP_PUSH, 16'd0, 6'd0, 10'd0, 1'b0, zero_px});
        add_row('{OP_FETCH, 16'd0, 6'd0, 10'd3, 1'b1, pixel_t'({1'b1, 24'h0})});
        add_row('{OP_FETCH, 16'd0, 6'd1, 10'd3, 1'b0, zero_px});
        add_row('{OP_FETCH, 16'd0, 6'd40, 10'd0, 1'b1, pixel_t'({1'b1, 24'hFFFFFF})});
        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].op, dir_rows[k].mag, dir_rows[k].age,
                         dir_rows[k].col, 1'b0);
            // typed-in expectation replaces the predicted one where given
            if (dir_rows[k].op == OP_FETCH && dir_rows[k].has_pix)
                pending_pixels[pending_pixels.size() - 1] = dir_rows[k].pix;
        end
        drain();

        // ramp with extrapolation below the first stop and reversed spans
        write_reg(REG_STOP_COUNT, STOP_W'(3'd7));
        write_reg(REG_STOP_FIRST, {17'd20000, 24'hFF00FF});
        write_reg(3'(REG_STOP_FIRST + 1), {17'd10000, 24'h00FF00});
        write_reg(3'(REG_STOP_FIRST + 2), {17'd40000, 24'h123456});
        write_reg(3'(REG_STOP_FIRST + 3), {17'd40000, 24'hFEDCBA});
        write_reg(3'(REG_STOP_FIRST + 4), {17'd131071, 24'hFFFFFF});
        write_reg(3'(REG_STOP_FIRST + 5), {17'd0, 24'h000000});
        for (int c = 0; c < 4; c++)
            send_request(OP_FETCH, 16'd0, 6'd0, c[9:0], 1'b0);
        drain();

        // random phases over several widths and ramps
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_reg(REG_ROW_WIDTH, STOP_W'(11'd1));
                1: write_reg(REG_ROW_WIDTH, STOP_W'(11'd0));
                2: write_reg(REG_ROW_WIDTH, STOP_W'(11'd2047));
                3: write_reg(REG_ROW_WIDTH, STOP_W'(11'd3));
                default: write_reg(REG_ROW_WIDTH, STOP_W'($urandom_range(1, 12)));
            endcase
            load_ramp($urandom_range(0, 7), phase % 2 == 0);
            quiet = (phase == 7);
            if (phase == 4)
                long_stall_req = 1'b1;
            for (int k = 0; k < 230; k++) begin
                m = 16'($urandom);
                if ($urandom_range(0, 3) == 0)
                    m = m >> $urandom_range(0, 15);
                if (phase == 2 && k < 120) begin
                    // wide row: push a short prefix first; later fetches find no committed row
                    send_request(OP_PUSH, m, 6'd0, 10'd0, !quiet);
                    pushes++;
                end else if ($urandom_range(0, 1) == 0) begin
                    send_request(OP_PUSH, m, 6'd0, 10'd0, !quiet);
                    pushes++;
                end else begin
                    send_request(OP_FETCH, 16'($urandom), 6'($urandom),
                                 ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                             : 10'($urandom_range(0, 15)),
                                 !quiet);
                    fetches++;
                end
                if (k == 100 && phase == 5) begin
                    // pause the sender until every pixel is back
                    release_input();
                    while (pending_pixels.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("ran %0d random pushes and %0d random fetches, %0d pixels checked",
                 pushes, fetches, pixels_seen);
        $display("covered widths 1..1024, empty and clamped fetches, 0..7 stop ramps");
        if (errors == 0 && pending_pixels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
